[rtl/core/psrb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the palette scale rotate blitter
package psrb_pkg;

    localparam int SIDE_REG_W = 11;
    localparam int CFG_IDX_W  = 8;
    localparam int CNT_OUT_W  = 10;

    localparam logic [SIDE_REG_W-1:0] LONG_SIDE_RST  = 11'd800;
    localparam logic [SIDE_REG_W-1:0] SHORT_SIDE_RST = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_SIDE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_SIDE = 8'd1;

    localparam logic [1:0] REQ_SRC_WR = 2'd0;
    localparam logic [1:0] REQ_PAL_WR = 2'd1;
    localparam logic [1:0] REQ_PULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] src_addr;
        logic [7:0]  pixel_value;
        logic [7:0]  pal_entry;
        logic [23:0] pal_rgb;
    } t_req;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] out_x;
        logic [CNT_OUT_W-1:0] out_y;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 end_of_row;
        logic                 end_of_frame;
    } t_res;

    typedef struct packed {
        logic div_start;
        logic load;
        logic src_wr;
        logic pal_wr;
        logic pull;
        logic rd_src;
        logic rd_pal;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

[rtl/core/palette_scale_rotate_blitter_top.sv]
`timescale 1ns / 1ps
// top level of the palette scale rotate blitter
// usage:
//   requests enter on i_req when start is high and busy is low. source pixel
//   and palette writes give no result; a pull returns the next portrait
//   panel pixel in raster order.
//   a pull result appears on o_res with o_res_valid high for one cycle, once
//   the source memory read and then the palette read have been registered.
//   the next request may be taken in the cycle the result is shown; a new
//   pull waits for the last result, and writes run at one per cycle while
//   busy is low. side registers are written on the cfg channel (index 0 long
//   side, index 1 short side); o_cfg_ready is always high. a side write
//   restarts the frame and runs the scale setup: two serial dividers, one bit
//   per cycle, with busy high.
//   reset loads sides 800 by 480 and runs the same setup; frame and palette
//   memories are not cleared.
//   results cannot be held off: each one is taken in the cycle it is shown.
module palette_scale_rotate_blitter_top #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int MAX_SIDE   = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  psrb_pkg::t_req                   i_req,
    output psrb_pkg::t_res                   o_res,
    output logic                             o_res_valid,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [psrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psrb_pkg::SIDE_REG_W-1:0]  i_cfg_data
);

    psrb_pkg::t_cmd  cmd;
    psrb_pkg::t_stat stat;
    logic            cfg_wr;
    logic            side_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign side_wr     = cfg_wr && ((i_cfg_index == psrb_pkg::REG_LONG_SIDE) ||
                                    (i_cfg_index == psrb_pkg::REG_SHORT_SIDE));

    psrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req.req_type),
        .i_cfg_wr    (side_wr),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (o_res_valid)
    );

    psrb_datapath #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .MAX_SIDE   (MAX_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res)
    );

endmodule

[rtl/core/psrb_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, result held until next start
module psrb_div #(
    parameter int N_W = 9,
    parameter int D_W = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo,
    output logic [D_W-1:0] o_rem
);

    localparam int C_W = $clog2(N_W + 1);

    logic           r_busy;
    logic [C_W-1:0] r_cnt;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           take;

    always_comb begin
        trial = {r_rem, r_quo[N_W-1]};
        take  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= C_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == C_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? diff[D_W-1:0] : trial[D_W-1:0];
            r_quo <= N_W'({r_quo, take});
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/core/psrb_datapath.sv]
`timescale 1ns / 1ps
// datapath: side registers, scale steppers, source frame and palette memories
module psrb_datapath #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int MAX_SIDE   = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  psrb_pkg::t_cmd                   i_cmd,
    output psrb_pkg::t_stat                  o_stat,
    input  psrb_pkg::t_req                   i_req,
    input  logic                             i_cfg_wr,
    input  logic [psrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psrb_pkg::SIDE_REG_W-1:0]  i_cfg_data,
    output psrb_pkg::t_res                   o_res
);

    localparam int SRC_SIZE = SRC_WIDTH * SRC_HEIGHT;
    localparam int SA_W     = (SRC_SIZE > 1) ? $clog2(SRC_SIZE) : 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int CNT_W    = $clog2(MAX_SIDE);
    localparam int SXQ_W    = $clog2(SRC_WIDTH + 1);
    localparam int SYQ_W    = $clog2(SRC_HEIGHT + 1);

    logic [psrb_pkg::SIDE_REG_W-1:0] r_long_side;
    logic [psrb_pkg::SIDE_REG_W-1:0] r_short_side;

    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [SXQ_W-1:0]  r_sxq, n_sxq;
    logic [SIDE_W-1:0] r_sxr, n_sxr;
    logic [SYQ_W-1:0]  r_syq, n_syq;
    logic [SIDE_W-1:0] r_syr, n_syr;

    logic [SA_W-1:0]   r_idx;
    logic [CNT_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_y;
    logic              r_eor;
    logic              r_eof;
    logic [7:0]        r_pix;
    logic [23:0]       r_rgb;

    logic [7:0]        r_src_mem [SRC_SIZE];
    logic [23:0]       r_pal_mem [256];

    logic [31:0]       long_i;
    logic [31:0]       short_i;
    logic [SIDE_W-1:0] ls;
    logic [SIDE_W-1:0] ss;
    logic              x_done;
    logic              y_done;
    logic [SXQ_W-1:0]  dqx;
    logic [SIDE_W-1:0] drx;
    logic [SYQ_W-1:0]  dqy;
    logic [SIDE_W-1:0] dry;
    logic              eor;
    logic              eof;
    logic [SA_W-1:0]   idx;
    logic [SIDE_W:0]   sx_sum;
    logic [SYQ_W-1:0]  sy_q0;
    logic [SIDE_W-1:0] sy_r0;
    logic              addr_ok;

    // side clamp into 1..MAX_SIDE
    always_comb begin
        long_i  = 32'(r_long_side);
        short_i = 32'(r_short_side);
        if (long_i == 32'd0) begin
            long_i = 32'd1;
        end else if (long_i > 32'(MAX_SIDE)) begin
            long_i = 32'(MAX_SIDE);
        end
        if (short_i == 32'd0) begin
            short_i = 32'd1;
        end else if (short_i > 32'(MAX_SIDE)) begin
            short_i = 32'(MAX_SIDE);
        end
        ls = SIDE_W'(long_i);
        ss = SIDE_W'(short_i);
    end

    psrb_div #(
        .N_W (SXQ_W),
        .D_W (SIDE_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (SXQ_W'(SRC_WIDTH)),
        .i_den   (ls),
        .o_done  (x_done),
        .o_quo   (dqx),
        .o_rem   (drx)
    );

    psrb_div #(
        .N_W (SYQ_W),
        .D_W (SIDE_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (SYQ_W'(SRC_HEIGHT)),
        .i_den   (ss),
        .o_done  (y_done),
        .o_quo   (dqy),
        .o_rem   (dry)
    );

    assign o_stat.div_done = x_done && y_done;

    always_comb begin
        eor     = (SIDE_W'(r_col) == ss - 1'b1);
        eof     = eor && (SIDE_W'(r_row) == ls - 1'b1);
        idx     = SA_W'(r_syq) * SA_W'(SRC_WIDTH) + SA_W'(r_sxq);
        sx_sum  = {1'b0, r_sxr} + {1'b0, drx};
        // start of a row: (ss-1)*H = ss*(H-dq) - dr
        sy_q0   = SYQ_W'(SRC_HEIGHT) - dqy - SYQ_W'(dry != '0);
        sy_r0   = (dry == '0) ? '0 : (ss - dry);
        addr_ok = (32'(i_req.src_addr) < 32'(SRC_SIZE));
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_sxq = r_sxq;
        n_sxr = r_sxr;
        n_syq = r_syq;
        n_syr = r_syr;
        if (i_cmd.load) begin
            n_col = '0;
            n_row = '0;
            n_sxq = '0;
            n_sxr = '0;
            n_syq = sy_q0;
            n_syr = sy_r0;
        end else if (i_cmd.pull) begin
            if (eof) begin
                n_col = '0;
                n_row = '0;
                n_sxq = '0;
                n_sxr = '0;
                n_syq = sy_q0;
                n_syr = sy_r0;
            end else if (eor) begin
                n_col = '0;
                n_row = r_row + 1'b1;
                n_syq = sy_q0;
                n_syr = sy_r0;
                if (sx_sum >= {1'b0, ls}) begin
                    n_sxr = SIDE_W'(sx_sum - {1'b0, ls});
                    n_sxq = r_sxq + dqx + 1'b1;
                end else begin
                    n_sxr = SIDE_W'(sx_sum);
                    n_sxq = r_sxq + dqx;
                end
            end else begin
                n_col = r_col + 1'b1;
                if (r_syr >= dry) begin
                    n_syr = r_syr - dry;
                    n_syq = r_syq - dqy;
                end else begin
                    n_syr = SIDE_W'({1'b0, r_syr} + {1'b0, ss} - {1'b0, dry});
                    n_syq = r_syq - dqy - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_side  <= psrb_pkg::LONG_SIDE_RST;
            r_short_side <= psrb_pkg::SHORT_SIDE_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_sxq        <= '0;
            r_sxr        <= '0;
            r_syq        <= '0;
            r_syr        <= '0;
        end else begin
            if (i_cfg_wr && (i_cfg_index == psrb_pkg::REG_LONG_SIDE)) begin
                r_long_side <= i_cfg_data;
            end
            if (i_cfg_wr && (i_cfg_index == psrb_pkg::REG_SHORT_SIDE)) begin
                r_short_side <= i_cfg_data;
            end
            r_col <= n_col;
            r_row <= n_row;
            r_sxq <= n_sxq;
            r_sxr <= n_sxr;
            r_syq <= n_syq;
            r_syr <= n_syr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull) begin
            r_idx <= idx;
            r_x   <= r_col;
            r_y   <= r_row;
            r_eor <= eor;
            r_eof <= eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_wr && addr_ok) begin
            r_src_mem[SA_W'(i_req.src_addr)] <= i_req.pixel_value;
        end
        if (i_cmd.rd_src) begin
            r_pix <= r_src_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr) begin
            r_pal_mem[i_req.pal_entry] <= i_req.pal_rgb;
        end
        if (i_cmd.rd_pal) begin
            r_rgb <= r_pal_mem[r_pix];
        end
    end

    always_comb begin
        o_res.out_x        = psrb_pkg::CNT_OUT_W'(r_x);
        o_res.out_y        = psrb_pkg::CNT_OUT_W'(r_y);
        o_res.red          = r_rgb[23:16];
        o_res.green        = r_rgb[15:8];
        o_res.blue         = r_rgb[7:0];
        o_res.end_of_row   = r_eor;
        o_res.end_of_frame = r_eof;
    end

endmodule

[rtl/core/psrb_ctrl.sv]
`timescale 1ns / 1ps
// controller: setup after reset or side write, request dispatch, read sequencing
module psrb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_req_type,
    input  logic            i_cfg_wr,
    input  psrb_pkg::t_stat i_stat,
    output psrb_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_res_valid
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_IDLE = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_busy      = !(r_state inside {S_IDLE, S_OUT});
    assign accept      = i_start && !o_busy;
    assign o_res_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd.div_start = (r_state == S_INIT);
        o_cmd.load      = (r_state == S_DIV) && i_stat.div_done && !i_cfg_wr;
        o_cmd.src_wr    = accept && (i_req_type == psrb_pkg::REQ_SRC_WR);
        o_cmd.pal_wr    = accept && (i_req_type == psrb_pkg::REQ_PAL_WR);
        o_cmd.pull      = accept && (i_req_type == psrb_pkg::REQ_PULL);
        o_cmd.rd_src    = (r_state == S_RD1);
        o_cmd.rd_pal    = (r_state == S_RD2);
    end

    always_comb begin
        n_state = r_state;
        if (i_cfg_wr) begin
            n_state = S_INIT;
        end else begin
            case (r_state)
                S_INIT: begin
                    n_state = S_DIV;
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE, S_OUT: begin
                    n_state = o_cmd.pull ? S_RD1 : S_IDLE;
                end
                S_RD1: begin
                    n_state = S_RD2;
                end
                S_RD2: begin
                    n_state = S_OUT;
                end
                default: begin
                    n_state = S_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/psrb_checker.sv]
`timescale 1ns / 1ps
// port level checker for the blitter top level and its bind
module psrb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input psrb_pkg::t_req                   i_req,
    input psrb_pkg::t_res                   o_res,
    input logic                             o_res_valid,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [psrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [psrb_pkg::SIDE_REG_W-1:0]  i_cfg_data
);

    logic pull_acc;

    assign pull_acc = start && !busy && (i_req.req_type == psrb_pkg::REQ_PULL);

    a_pull_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pull_acc |-> ##3 o_res_valid)
        else $error("pull transaction without result three cycles later");

    a_result_has_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(pull_acc, 3))
        else $error("result without matching pull transaction");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("results in consecutive cycles");

    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.end_of_frame) |-> o_res.end_of_row)
        else $error("end of frame without end of row");

endmodule

bind palette_scale_rotate_blitter_top psrb_checker u_psrb_checker (.*);

[test/palette_scale_rotate_blitter_top_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the palette scale rotate blitter: random pulls and writes
module palette_scale_rotate_blitter_top_test;

    localparam int SRC_W       = 320;
    localparam int SRC_H       = 200;
    localparam int MAX_SIDE    = 1024;
    localparam int SRC_PIXELS  = SRC_W * SRC_H;
    localparam int SETTLE      = 4;
    localparam int TAIL        = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    localparam logic [psrb_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [1:0]                     REQ_NONE  = 2'd3;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic                            busy;
    psrb_pkg::t_req                  i_req       = '0;
    psrb_pkg::t_res                  o_res;
    logic                            o_res_valid;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [psrb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [psrb_pkg::SIDE_REG_W-1:0] i_cfg_data  = '0;

    palette_scale_rotate_blitter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // blitter state as seen by accepted transactions
    logic [7:0]                      frame_mem [SRC_PIXELS];
    logic [23:0]                     pal_mem [256];
    int unsigned                     pix_col, pix_row;
    logic [psrb_pkg::SIDE_REG_W-1:0] long_reg  = psrb_pkg::LONG_SIDE_RST;
    logic [psrb_pkg::SIDE_REG_W-1:0] short_reg = psrb_pkg::SHORT_SIDE_RST;

    // state as planned by the stimulus, used to keep every read defined
    logic [7:0]                      plan_frame [SRC_PIXELS];
    bit                              plan_frame_set [SRC_PIXELS];
    bit                              plan_pal_set [256];
    int unsigned                     plan_col, plan_row;
    logic [psrb_pkg::SIDE_REG_W-1:0] plan_long  = psrb_pkg::LONG_SIDE_RST;
    logic [psrb_pkg::SIDE_REG_W-1:0] plan_short = psrb_pkg::SHORT_SIDE_RST;

    psrb_pkg::t_req blit_reqs[$];
    psrb_pkg::t_res pixels_due[$];
    int   idle_pct = 37;
    int   errors, cycle_count, pixel_count, frame_count;
    int   src_writes, src_dropped, pal_writes, spare_reqs, side_writes;

    function automatic int unsigned side_eff(logic [psrb_pkg::SIDE_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    // panel position of a pull, the source address it reads, the counters after it
    function automatic void raster_pos(input int unsigned col, input int unsigned row,
            input logic [psrb_pkg::SIDE_REG_W-1:0] ls_r,
            input logic [psrb_pkg::SIDE_REG_W-1:0] ss_r,
            output int unsigned x, output int unsigned y, output int unsigned addr,
            output bit eor, output bit eof, output int unsigned nx, output int unsigned ny);
        int unsigned ls, ss, sx, sy;
        ls = side_eff(ls_r);
        ss = side_eff(ss_r);
        x = (col >= ss) ? ss - 1 : col;
        y = (row >= ls) ? ls - 1 : row;
        sx = (y * SRC_W) / ls;
        sy = ((ss - 1 - x) * SRC_H) / ss;
        if (sx >= SRC_W) sx = SRC_W - 1;
        if (sy >= SRC_H) sy = SRC_H - 1;
        addr = sy * SRC_W + sx;
        eor = (x == ss - 1);
        eof = eor && (y == ls - 1);
        nx = eor ? 0 : x + 1;
        ny = eof ? 0 : (eor ? y + 1 : y);
    endfunction

    function automatic psrb_pkg::t_res next_panel_pixel();
        int unsigned    x, y, addr, nx, ny;
        bit             eor, eof;
        logic [23:0]    rgb;
        psrb_pkg::t_res p;
        raster_pos(pix_col, pix_row, long_reg, short_reg, x, y, addr, eor, eof, nx, ny);
        rgb = pal_mem[frame_mem[addr]];
        p.out_x        = x[psrb_pkg::CNT_OUT_W-1:0];
        p.out_y        = y[psrb_pkg::CNT_OUT_W-1:0];
        p.red          = rgb[23:16];
        p.green        = rgb[15:8];
        p.blue         = rgb[7:0];
        p.end_of_row   = eor;
        p.end_of_frame = eof;
        pix_col = nx;
        pix_row = ny;
        return p;
    endfunction

    function automatic void take_req(psrb_pkg::t_req r);
        case (r.req_type)
            psrb_pkg::REQ_SRC_WR: begin
                if (r.src_addr < SRC_PIXELS) begin
                    frame_mem[r.src_addr] = r.pixel_value;
                    src_writes++;
                end else begin
                    src_dropped++;
                end
            end
            psrb_pkg::REQ_PAL_WR: begin
                pal_mem[r.pal_entry] = r.pal_rgb;
                pal_writes++;
            end
            psrb_pkg::REQ_PULL: pixels_due.push_back(next_panel_pixel());
            default: spare_reqs++;
        endcase
    endfunction

    function automatic void take_side(logic [psrb_pkg::CFG_IDX_W-1:0] idx,
                                      logic [psrb_pkg::SIDE_REG_W-1:0] v);
        side_writes++;
        case (idx)
            psrb_pkg::REG_LONG_SIDE: long_reg = v;
            psrb_pkg::REG_SHORT_SIDE: short_reg = v;
            default: return;
        endcase
        pix_col = 0;
        pix_row = 0;
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= REPORT_MAX) $display("error at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic string pixel_str(psrb_pkg::t_res p);
        return $sformatf("(x %0d y %0d rgb %02h_%02h_%02h row_end %0b frame_end %0b)",
                         p.out_x, p.out_y, p.red, p.green, p.blue,
                         p.end_of_row, p.end_of_frame);
    endfunction

    function automatic psrb_pkg::t_req rand_req(logic [1:0] kind);
        logic [63:0]    raw;
        psrb_pkg::t_req r;
        raw = {$urandom, $urandom};
        r = raw[$bits(psrb_pkg::t_req)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    function automatic void plan_req(psrb_pkg::t_req r);
        int unsigned x, y, addr, nx, ny;
        bit          eor, eof;
        case (r.req_type)
            psrb_pkg::REQ_SRC_WR: begin
                if (r.src_addr < SRC_PIXELS) begin
                    plan_frame[r.src_addr]     = r.pixel_value;
                    plan_frame_set[r.src_addr] = 1'b1;
                end
            end
            psrb_pkg::REQ_PAL_WR: plan_pal_set[r.pal_entry] = 1'b1;
            psrb_pkg::REQ_PULL: begin
                raster_pos(plan_col, plan_row, plan_long, plan_short,
                           x, y, addr, eor, eof, nx, ny);
                plan_col = nx;
                plan_row = ny;
            end
            default: ;
        endcase
        blit_reqs.push_back(r);
    endfunction

    function automatic int unsigned next_pull_addr();
        int unsigned x, y, addr, nx, ny;
        bit          eor, eof;
        raster_pos(plan_col, plan_row, plan_long, plan_short, x, y, addr, eor, eof, nx, ny);
        return addr;
    endfunction

    // a pull, preceded by the writes that make both stores it reads defined
    function automatic void plan_pull();
        int unsigned    addr;
        psrb_pkg::t_req r;
        addr = next_pull_addr();
        if (!plan_frame_set[addr]) begin
            r = rand_req(psrb_pkg::REQ_SRC_WR);
            r.src_addr = 16'(addr);
            plan_req(r);
        end
        if (!plan_pal_set[plan_frame[addr]]) begin
            r = rand_req(psrb_pkg::REQ_PAL_WR);
            r.pal_entry = plan_frame[addr];
            plan_req(r);
        end
        plan_req(rand_req(psrb_pkg::REQ_PULL));
    endfunction

    function automatic void plan_random(int n);
        int unsigned    pick, addr;
        psrb_pkg::t_req r;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            addr = next_pull_addr();
            if (pick < 50) begin
                plan_pull();
            end else if (pick < 80) begin
                r = rand_req(psrb_pkg::REQ_SRC_WR);
                case ($urandom_range(0, 9))
                    0: r.src_addr = 16'($urandom_range(SRC_PIXELS, 16'hFFFF));
                    1, 2, 3, 4: r.src_addr = 16'(addr);
                    default: r.src_addr = 16'($urandom_range(0, SRC_PIXELS - 1));
                endcase
                plan_req(r);
            end else if (pick < 92) begin
                r = rand_req(psrb_pkg::REQ_PAL_WR);
                if ($urandom_range(0, 1) == 1 && plan_frame_set[addr])
                    r.pal_entry = plan_frame[addr];
                plan_req(r);
            end else begin
                plan_req(rand_req(REQ_NONE));
            end
        end
    endfunction

    task automatic wait_drained();
        while (blit_reqs.size() != 0 || start || pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_side(logic [psrb_pkg::CFG_IDX_W-1:0] idx,
                            logic [psrb_pkg::SIDE_REG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == psrb_pkg::REG_LONG_SIDE || idx == psrb_pkg::REG_SHORT_SIDE) begin
            if (idx == psrb_pkg::REG_LONG_SIDE) plan_long = v;
            else plan_short = v;
            plan_col = 0;
            plan_row = 0;
        end
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        bit taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) take_side(i_cfg_index, i_cfg_data);
            taken = start && !busy;
            if (taken) take_req(i_req);
            if (taken || !start) begin
                if (blit_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_req <= blit_reqs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        psrb_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pixels_due.size() == 0) begin
                flag_error($sformatf("pixel with no pull pending: %s", pixel_str(o_res)));
            end else begin
                want = pixels_due.pop_front();
                if (o_res.out_x !== want.out_x || o_res.out_y !== want.out_y ||
                    o_res.red !== want.red || o_res.green !== want.green ||
                    o_res.blue !== want.blue || o_res.end_of_row !== want.end_of_row ||
                    o_res.end_of_frame !== want.end_of_frame)
                    flag_error($sformatf("pixel differs: want %s got %s",
                                         pixel_str(want), pixel_str(o_res)));
                pixel_count++;
                if (want.end_of_frame) frame_count++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("palette_scale_rotate_blitter_top: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        psrb_pkg::t_req r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of the fields at the reset sides
        r = rand_req(psrb_pkg::REQ_PAL_WR);
        r.pal_entry = 8'h00;
        r.pal_rgb   = 24'h000000;
        plan_req(r);
        r = rand_req(psrb_pkg::REQ_PAL_WR);
        r.pal_entry = 8'hFF;
        r.pal_rgb   = 24'hFFFFFF;
        plan_req(r);
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr    = 16'd0;
        r.pixel_value = 8'hFF;
        plan_req(r);
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr    = 16'(SRC_PIXELS - 1);
        r.pixel_value = 8'h00;
        plan_req(r);
        // writes past the end of the frame are dropped
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr = 16'(SRC_PIXELS);
        plan_req(r);
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr = 16'hFFFF;
        plan_req(r);
        r = '1;
        plan_req(r);
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr    = 16'(next_pull_addr());
        r.pixel_value = 8'hFF;
        plan_req(r);
        plan_pull();
        r = rand_req(psrb_pkg::REQ_SRC_WR);
        r.src_addr    = 16'(next_pull_addr());
        r.pixel_value = 8'h00;
        plan_req(r);
        plan_pull();
        repeat (4) plan_pull();
        wait_drained();
        plan_random(150);
        wait_drained();

        // zero sides count as one, so every pull ends a frame
        set_side(psrb_pkg::REG_LONG_SIDE, '0);
        set_side(psrb_pkg::REG_SHORT_SIDE, '0);
        repeat (3) plan_pull();
        plan_random(100);
        wait_drained();

        // oversize sides clamp to the maximum
        set_side(psrb_pkg::REG_LONG_SIDE, '1);
        set_side(psrb_pkg::REG_SHORT_SIDE, 11'd1025);
        plan_random(200);
        wait_drained();

        idle_pct = 0;
        set_side(psrb_pkg::REG_LONG_SIDE, 11'd3);
        set_side(psrb_pkg::REG_SHORT_SIDE, 11'd2);
        plan_random(250);
        wait_drained();
        idle_pct = 37;

        set_side(psrb_pkg::REG_LONG_SIDE, 11'd1);
        set_side(psrb_pkg::REG_SHORT_SIDE, 11'd1024);
        plan_random(150);
        wait_drained();

        set_side(psrb_pkg::REG_LONG_SIDE, 11'd1024);
        set_side(psrb_pkg::REG_SHORT_SIDE, 11'd1);
        plan_random(150);
        wait_drained();

        set_side(psrb_pkg::REG_LONG_SIDE, 11'd7);
        set_side(psrb_pkg::REG_SHORT_SIDE, 11'd5);
        plan_random(120);
        wait_drained();

        // unused index keeps the frame position
        set_side(REG_SPARE, 11'd9);
        plan_random(130);
        wait_drained();

        // one side only, mid frame
        set_side(psrb_pkg::REG_LONG_SIDE, 11'd13);
        plan_random(200);
        wait_drained();

        set_side(psrb_pkg::REG_SHORT_SIDE, psrb_pkg::SHORT_SIDE_RST);
        set_side(psrb_pkg::REG_LONG_SIDE, psrb_pkg::LONG_SIDE_RST);
        plan_random(150);
        wait_drained();

        repeat (TAIL) @(posedge i_clk);
        if (pixels_due.size() != 0)
            flag_error($sformatf("%0d pulls never answered", pixels_due.size()));
        $display("covered %0d panel pixels over %0d whole frames, %0d source writes, %0d dropped",
                 pixel_count, frame_count, src_writes, src_dropped);
        $display("plus %0d palette writes, %0d unused requests, %0d side writes; %0d errors",
                 pal_writes, spare_reqs, side_writes, errors);
        if (errors == 0) begin
            $display("palette_scale_rotate_blitter_top: match");
        end else begin
            $display("palette_scale_rotate_blitter_top: mismatch");
        end
        $finish;
    end

endmodule

[palette_scale_rotate_blitter_top.f]
rtl/core/psrb_pkg.sv
rtl/core/psrb_div.sv
rtl/core/psrb_datapath.sv
rtl/core/psrb_ctrl.sv
rtl/core/palette_scale_rotate_blitter_top.sv
rtl/core/psrb_checker.sv
test/palette_scale_rotate_blitter_top_test.sv
